[hdl/assert_macros.svh]
// Assertion macros shared by the nibble trie lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hdl/ntl_pkg.sv]
// Types and constants of the nibble trie lookup.
package ntl_pkg;

	localparam int STATES      = 1024;
	localparam int SYMBOLS     = 16;
	localparam int KEY_NIBBLES = 8;

	localparam int KIND_W   = 2;
	localparam int STATE_W  = 10;
	localparam int SYM_W    = 4;
	localparam int VAL_W    = 11;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 8;
	localparam int NEXT_AW  = STATE_W + SYM_W;
	localparam int NEXT_DEPTH = STATES * SYMBOLS;
	localparam int CNT_W    = $clog2(KEY_NIBBLES + 1);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register index of initial_state.
	localparam logic REG_INIT = 1'b0;

	// Reset value of initial_state: empty automaton.
	localparam logic signed [VAL_W-1:0] NO_STATE = -11'sd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_WR_NEXT   = 2'd0,
		KIND_WR_STATUS = 2'd1,
		KIND_LOOKUP    = 2'd2
	} kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic take_en;   // input channel open
		logic step;      // read next transition from last state
		logic stat_rd;   // read status of last state
		logic load_out;  // load result register
		logic miss;      // result is a miss
	} ntl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic lookup_go; // lookup item accepted
		logic init_ok;   // initial state is a real state
		logic rd_ok;     // last transition read is a real state
		logic out_free;  // result register can take a new item
	} ntl_stat_t;

	// True when a signed state value names an existing state.
	function automatic logic state_ok(input logic signed [VAL_W-1:0] s);
		return !s[VAL_W-1] && (int'(s[VAL_W-2:0]) < STATES);
	endfunction

endpackage

[hdl/ntl_in_if.sv]
// Input channel of the nibble trie lookup.
interface ntl_in_if
	import ntl_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic [STATE_W-1:0]         entry_state;
	logic [SYM_W-1:0]           entry_symbol;
	logic signed [VAL_W-1:0]    entry_value;
	logic [KEY_W-1:0]           key;

	modport source (output valid, kind, entry_state, entry_symbol, entry_value, key,
		input ready);
	modport sink (input valid, kind, entry_state, entry_symbol, entry_value, key,
		output ready);
endinterface

[hdl/ntl_out_if.sv]
// Result channel of the nibble trie lookup.
interface ntl_out_if
	import ntl_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                missed;

	modport source (output valid, status, missed, input ready);
	modport sink (input valid, status, missed, output ready);
endinterface

[hdl/ntl_ctrl.sv]
// Controller state machine of the nibble trie lookup.
module ntl_ctrl
	import ntl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ntl_stat_t st,
	output ntl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             miss_q;
	logic             last;

	assign last = (cnt_q == CNT_W'(KEY_NIBBLES));

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		cmd.miss = miss_q;
		case (state_q)
			S_IDLE: cmd.take_en = 1'b1;
			S_WALK: begin
				if (st.rd_ok) begin
					if (last) cmd.stat_rd = 1'b1;
					else cmd.step = 1'b1;
				end
			end
			S_FIN: cmd.load_out = st.out_free;
			default: cmd = '0;
		endcase
	end

	// Advance the walk one nibble per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			miss_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (st.lookup_go) begin
						cnt_q <= CNT_W'(1);
						if (st.init_ok) begin
							miss_q  <= 1'b0;
							state_q <= S_WALK;
						end else begin
							miss_q  <= 1'b1;
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					if (!st.rd_ok) begin
						miss_q  <= 1'b1;
						state_q <= S_FIN;
					end else if (last) begin
						miss_q  <= 1'b0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_FIN: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/ntl_dp.sv]
// Datapath of the nibble trie lookup: tables, walk registers, result register.
module ntl_dp
	import ntl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	ntl_in_if.sink            in_ch,
	ntl_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	input  ntl_cmd_t          cmd,
	output ntl_stat_t         st
);

	logic [VAL_W-1:0]    next_mem [NEXT_DEPTH];
	logic [STATUS_W-1:0] stat_mem [STATES];

	logic signed [VAL_W-1:0] init_q;
	logic signed [VAL_W-1:0] rd_q;
	logic [STATUS_W-1:0]     stat_rd_q;
	logic [KEY_W-1:0]        key_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic                    out_missed_q;

	logic               in_take;
	logic               wr_next;
	logic               wr_stat;
	logic               est_ok;
	logic               rd_en;
	logic [NEXT_AW-1:0] rd_addr;

	// Decode the accepted item
	assign in_ch.ready = cmd.take_en;
	assign in_take     = in_ch.valid && in_ch.ready;
	assign est_ok      = int'(in_ch.entry_state) < STATES;
	assign wr_next     = in_take && (in_ch.kind == KIND_WR_NEXT) && est_ok;
	assign wr_stat     = in_take && (in_ch.kind == KIND_WR_STATUS) && est_ok;

	assign st.lookup_go = in_take && (in_ch.kind == KIND_LOOKUP);
	assign st.init_ok   = state_ok(init_q);
	assign st.rd_ok     = state_ok(rd_q);
	assign st.out_free  = !out_valid_q || out_ch.ready;

	// Select the next transition address: start from initial state or last read
	assign rd_en   = st.lookup_go || cmd.step;
	assign rd_addr = st.lookup_go ?
		{init_q[STATE_W-1:0], in_ch.key[KEY_W-1 -: SYM_W]} :
		{rd_q[STATE_W-1:0], key_q[KEY_W-1 -: SYM_W]};

	// Transition memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_next) next_mem[{in_ch.entry_state, in_ch.entry_symbol}] <= in_ch.entry_value;
		if (rd_en) rd_q <= next_mem[rd_addr];
	end

	// Status memory
	always_ff @(posedge clk) begin
		if (wr_stat) stat_mem[in_ch.entry_state] <= in_ch.entry_value[STATUS_W-1:0];
		if (cmd.stat_rd) stat_rd_q <= stat_mem[rd_q[STATE_W-1:0]];
	end

	// Shift key so the next nibble sits on top
	always_ff @(posedge clk) begin
		if (st.lookup_go) key_q <= in_ch.key << SYM_W;
		else if (cmd.step) key_q <= key_q << SYM_W;
	end

	// Hold initial state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= NO_STATE;
		end else if (psel && penable && pwrite && (paddr[2] == REG_INIT)) begin
			init_q <= pwdata[VAL_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_INIT) ? APB_DW'(init_q) : '0;

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= cmd.miss ? '0 : stat_rd_q;
			out_missed_q <= cmd.miss;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = out_status_q;
	assign out_ch.missed = out_missed_q;

endmodule

[hdl/nibble_trie_lookup.sv]
// Lookup: a lookup item is walked by eight dependent transition-memory reads, the first at the
// accepting edge, then one status read and the load of the result register, which waits while it is full.
// No new item is taken until the result of a lookup is loaded; a miss ends the walk early;
// write items are taken one per cycle while no lookup is in progress. A result waits in its own register.
// Reset: control cleared, initial_state set to -1; the tables are undefined until written.
`include "assert_macros.svh"

module nibble_trie_lookup
	import ntl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	ntl_in_if.sink            in_ch,
	ntl_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	ntl_cmd_t  cmd;
	ntl_stat_t st;

	assign pready = 1'b1;

	ntl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	ntl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cmd     (cmd),
		.st      (st)
	);

	// Check controller and datapath agree on hand-offs
	`ASSERT_SAME(a_idle_no_load, clk, arst_n, cmd.take_en, !cmd.load_out, "load while idle")
	`ASSERT_SAME(a_load_free, clk, arst_n, cmd.load_out, st.out_free, "result overwritten")
	`ASSERT_NEXT(a_busy_after_go, clk, arst_n, st.lookup_go, !cmd.take_en, "input open mid walk")
	`ASSERT_SAME(a_one_read, clk, arst_n, cmd.step, !cmd.stat_rd, "two reads in one cycle")

endmodule

[tb/sv/tb_nibble_trie_lookup.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the nibble trie lookup: table writes and key walks under stalls.
module tb_nibble_trie_lookup;
	import ntl_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 200;
	localparam int POOL_SIZE     = 16;
	localparam int MAX_REPORTS   = 10;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef logic signed [VAL_W-1:0] sval_t;
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                missed;
	} answer_t;

	// Tracks the tables and start state, predicts each walk, checks returned answers.
	class lookup_scoreboard;
		sval_t               next_tbl [NEXT_DEPTH];
		logic [STATUS_W-1:0] status_tbl [STATES];
		sval_t               start_state;
		answer_t             answers_due [$];
		int                  errors;
		int                  lookups;
		int                  misses;
		int                  writes;

		function new();
			start_state = NO_STATE;
			errors = 0;
			lookups = 0;
			misses = 0;
			writes = 0;
		endfunction

		static function logic is_live(sval_t s);
			return !s[VAL_W-1] && (int'(s[STATE_W-1:0]) < STATES);
		endfunction

		// Walk the key from the start state, top nibble first.
		function answer_t walk_key(logic [KEY_W-1:0] key);
			sval_t   s;
			answer_t a;
			s = start_state;
			for (int k = 0; k < KEY_NIBBLES; k++) begin
				if (is_live(s))
					s = next_tbl[{s[STATE_W-1:0], key[KEY_W-1-SYM_W*k -: SYM_W]}];
			end
			if (is_live(s)) begin
				a.status = status_tbl[s[STATE_W-1:0]];
				a.missed = 1'b0;
			end else begin
				a.status = '0;
				a.missed = 1'b1;
			end
			return a;
		endfunction

		function void note_item(logic [KIND_W-1:0] kind, logic [STATE_W-1:0] est,
			logic [SYM_W-1:0] esym, sval_t eval, logic [KEY_W-1:0] key);
			answer_t a;
			case (kind)
				KIND_WR_NEXT: begin
					next_tbl[{est, esym}] = eval;
					writes++;
				end
				KIND_WR_STATUS: begin
					status_tbl[est] = eval[STATUS_W-1:0];
					writes++;
				end
				KIND_LOOKUP: begin
					a = walk_key(key);
					answers_due.insert(answers_due.size(), a);
					lookups++;
					if (a.missed)
						misses++;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic missed);
			answer_t want;
			if (answers_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR %0t: answer status=%0h missed=%0b with no lookup pending",
						$time, status, missed);
				return;
			end
			want = answers_due.pop_front();
			if (want.status !== status || want.missed !== missed) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR %0t: expected status=%0h missed=%0b, got status=%0h missed=%0b",
						$time, want.status, want.missed, status, missed);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	ntl_in_if  in_if ();
	ntl_out_if out_if ();

	nibble_trie_lookup dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lookup_scoreboard sb = new();

	// Stimulus-side copy of what has been written, so no walk reads an empty entry.
	sval_t          plan_next [NEXT_DEPTH];
	bit             plan_next_set [NEXT_DEPTH];
	bit             plan_status_set [STATES];
	sval_t          plan_start;
	sval_t          state_pool [POOL_SIZE];
	logic [KEY_W-1:0] key_log [$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	bit hold_done;
	int items_sent;
	int cycle_count;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Observe both channels
	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready)
			sb.note_item(in_if.kind, in_if.entry_state, in_if.entry_symbol,
				in_if.entry_value, in_if.key);
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_result(out_if.status, out_if.missed);
	end

	// Drive result ready: random stalls, plus one long hold-off on request
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one item and hold it until accepted
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] est,
		input logic [SYM_W-1:0] esym, input sval_t eval, input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid        <= 1'b1;
		in_if.kind         <= kind;
		in_if.entry_state  <= est;
		in_if.entry_symbol <= esym;
		in_if.entry_value  <= eval;
		in_if.key          <= key;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		if (kind == KIND_WR_NEXT) begin
			plan_next[{est, esym}] = eval;
			plan_next_set[{est, esym}] = 1'b1;
		end else if (kind == KIND_WR_STATUS) begin
			plan_status_set[est] = 1'b1;
		end
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	function automatic sval_t pick_next(input int miss_pct);
		if ($urandom_range(99) < miss_pct)
			return NO_STATE;
		if ($urandom_range(3) == 0)
			return sval_t'($urandom_range(STATES - 1));
		return state_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// Status values: all byte values, -1 and values above a byte (low byte kept)
	function automatic sval_t pick_status();
		case ($urandom_range(5))
			0: return NO_STATE;
			1: return sval_t'($urandom_range(STATES - 1));
			default: return sval_t'($urandom_range(255));
		endcase
	endfunction

	// Fill any missing entries along the key's path, then look it up
	task automatic lookup_key(input logic [KEY_W-1:0] key, input int miss_pct);
		sval_t              s;
		logic [NEXT_AW-1:0] idx;
		s = plan_start;
		for (int k = 0; k < KEY_NIBBLES; k++) begin
			if (lookup_scoreboard::is_live(s)) begin
				idx = {s[STATE_W-1:0], key[KEY_W-1-SYM_W*k -: SYM_W]};
				if (!plan_next_set[idx])
					send_item(KIND_WR_NEXT, idx[NEXT_AW-1:SYM_W], idx[SYM_W-1:0],
						pick_next(miss_pct), KEY_W'($urandom()));
				s = plan_next[idx];
			end
		end
		if (lookup_scoreboard::is_live(s) && !plan_status_set[s[STATE_W-1:0]])
			send_item(KIND_WR_STATUS, s[STATE_W-1:0], SYM_W'($urandom()), pick_status(),
				KEY_W'($urandom()));
		send_item(KIND_LOOKUP, STATE_W'($urandom()), SYM_W'($urandom()),
			sval_t'($urandom()), key);
		key_log.insert(key_log.size(), key);
		if (key_log.size() > 64)
			void'(key_log.pop_front());
	endtask

	// APB write of the start state; only called with the block idle
	task automatic set_start(input sval_t v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * int'(REG_INIT));
		pwdata  <= {{(APB_DW - VAL_W){v[VAL_W-1]}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		plan_start = v;
		sb.start_state = v;
	endtask

	// Drop valid, wait for all answers, then let the pipeline settle
	task automatic drain();
		in_if.valid <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly lookups on random keys and mutated known keys, with overwrites and ignored kinds
	task automatic run_segment(input int n_items);
		int               goal;
		int               pick;
		int               nib;
		logic [KEY_W-1:0] k;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				if (key_log.size() > 0 && $urandom_range(99) < 60) begin
					k = key_log[$urandom_range(key_log.size() - 1)];
					nib = $urandom_range(KEY_NIBBLES - 1);
					k[SYM_W*nib +: SYM_W] = SYM_W'($urandom());
				end else begin
					k = KEY_W'($urandom());
				end
				lookup_key(k, 10);
			end else if (pick < 75) begin
				send_item(KIND_WR_NEXT,
					($urandom_range(1) == 0) ? state_pool[$urandom_range(POOL_SIZE - 1)][STATE_W-1:0]
						: STATE_W'($urandom()),
					SYM_W'($urandom()), pick_next(30), KEY_W'($urandom()));
			end else if (pick < 92) begin
				send_item(KIND_WR_STATUS, STATE_W'($urandom()), SYM_W'($urandom()),
					pick_status(), KEY_W'($urandom()));
			end else begin
				send_item(KIND_UNUSED, STATE_W'($urandom()), SYM_W'($urandom()),
					sval_t'($urandom()), KEY_W'($urandom()));
			end
		end
	endtask

	initial begin
		sval_t seg_start [SEGMENTS];

		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		in_if.valid        = 1'b0;
		in_if.kind         = KIND_LOOKUP;
		in_if.entry_state  = '0;
		in_if.entry_symbol = '0;
		in_if.entry_value  = '0;
		in_if.key          = '0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		hold_req           = 1'b0;
		hold_done          = 1'b0;
		items_sent         = 0;
		plan_start         = NO_STATE;

		state_pool[0] = sval_t'(0);
		state_pool[1] = sval_t'(STATES - 1);
		for (int i = 2; i < POOL_SIZE; i++)
			state_pool[i] = sval_t'($urandom_range(STATES - 1));

		// Hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty automaton from reset, then after an explicit write of -1
		lookup_key(32'h1234_5678, 0);
		drain();
		set_start(NO_STATE);
		lookup_key(32'hFFFF_FFFF, 0);
		drain();
		set_start(sval_t'(0));

		// Self loop on state 0 for nibble 0; status keeps only the low byte
		send_item(KIND_WR_NEXT, 10'd0, 4'h0, sval_t'(0), '0);
		send_item(KIND_WR_STATUS, 10'd0, 4'h0, sval_t'(11'h155), '0);
		lookup_key(32'h0000_0000, 0);
		// Top state on nibble F; status of -1 reads back as 255
		send_item(KIND_WR_NEXT, 10'd0, 4'hF, sval_t'(STATES - 1), '0);
		send_item(KIND_WR_NEXT, 10'd1023, 4'hF, sval_t'(STATES - 1), '0);
		send_item(KIND_WR_STATUS, 10'd1023, 4'h0, NO_STATE, '0);
		lookup_key(32'hFFFF_FFFF, 0);
		// Missing transition at the first, a middle and the last nibble
		send_item(KIND_WR_NEXT, 10'd0, 4'h5, NO_STATE, '0);
		lookup_key(32'h5000_0000, 0);
		send_item(KIND_WR_NEXT, 10'd1023, 4'h0, NO_STATE, '0);
		lookup_key(32'hF000_0000, 0);
		send_item(KIND_WR_NEXT, 10'd0, 4'h7, NO_STATE, '0);
		lookup_key(32'h0000_0007, 0);
		// Walk back from the top state into state 0
		send_item(KIND_WR_NEXT, 10'd1023, 4'hA, sval_t'(0), '0);
		lookup_key(32'hFA00_0000, 0);
		// Unused kind must leave the tables alone
		send_item(KIND_UNUSED, 10'd0, 4'h0, NO_STATE, 32'hFFFF_FFFF);
		send_item(KIND_WR_STATUS, 10'd0, 4'h3, sval_t'(11'h2AA), 32'hFFFF_FFFF);
		lookup_key(32'h0000_0000, 0);
		lookup_key(32'hFA00_0000, 0);
		drain();

		// Random segments: start state and stall profile change between them
		seg_start[0] = sval_t'(STATES - 1);
		seg_start[1] = NO_STATE;
		seg_start[2] = state_pool[$urandom_range(2, POOL_SIZE - 1)];
		seg_start[3] = sval_t'(0);
		seg_start[4] = sval_t'($urandom_range(STATES - 1));
		seg_start[5] = sval_t'(STATES - 1);
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_start(seg_start[seg]);
			if (seg == SEGMENTS - 1)
				hold_req = 1'b1;
			run_segment(SEGMENT_ITEMS);
			drain();
		end

		$display("Ran %0d items: %0d lookups (%0d misses), %0d table writes",
			items_sent, sb.lookups, sb.misses, sb.writes);
		$display("Start states -1, 0, 1023 and random; both sides stalled; one long result hold-off");
		if (sb.answers_due.size() != 0)
			$display("ERROR: %0d expected answers never arrived", sb.answers_due.size());
		if (sb.errors == 0 && sb.answers_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/ntl_pkg.sv
hdl/ntl_in_if.sv
hdl/ntl_out_if.sv
hdl/ntl_ctrl.sv
hdl/ntl_dp.sv
hdl/nibble_trie_lookup.sv
tb/sv/tb_nibble_trie_lookup.sv
